>>> rtl/core/mbs_pkg.sv
// mbs_pkg: setup step codes, command codes and shared types
// of the modem bring-up sequencer; depends on nothing
`timescale 1ns / 1ps

package mbs_pkg;

	localparam int unsigned STEP_W    = 4;
	localparam int unsigned CMD_W     = 4;
	localparam int unsigned TIMEOUT_W = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd280;
	localparam logic [TIMEOUT_W-1:0] COUNT_TOP     = 16'hFFFF;

	// setup steps
	localparam logic [STEP_W-1:0] ST_IDENT   = 4'd0;
	localparam logic [STEP_W-1:0] ST_SIM     = 4'd1;
	localparam logic [STEP_W-1:0] ST_PIN     = 4'd2;
	localparam logic [STEP_W-1:0] ST_GET_FUN = 4'd3;
	localparam logic [STEP_W-1:0] ST_SET_FUN = 4'd4;
	localparam logic [STEP_W-1:0] ST_GET_ATT = 4'd5;
	localparam logic [STEP_W-1:0] ST_SET_ATT = 4'd6;
	localparam logic [STEP_W-1:0] ST_NET     = 4'd7;
	localparam logic [STEP_W-1:0] ST_READY   = 4'd8;

	// modem commands
	localparam logic [CMD_W-1:0] CMD_NONE    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_IDENT   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_SIM     = 4'd2;
	localparam logic [CMD_W-1:0] CMD_PIN     = 4'd3;
	localparam logic [CMD_W-1:0] CMD_SETFULL = 4'd4;
	localparam logic [CMD_W-1:0] CMD_GETFUN  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_SETATT  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_GETATT  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_NETSTAT = 4'd8;
	localparam logic [CMD_W-1:0] CMD_SIGNAL  = 4'd9;

	typedef struct packed {
		logic network_registered;
		logic packet_attached;
		logic full_function;
		logic pin_ready;
		logic sim_inserted;
		logic identified;
	} status_t;

	typedef struct packed {
		logic [STEP_W-1:0]    setup_step;
		logic                 tick_parity;
		logic                 long_wait;
		logic [TIMEOUT_W-1:0] attach_wait_count;
	} seq_state_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             ready_res;
	} result_t;

endpackage

>>> rtl/core/mbs_step.sv
// mbs_step: next-state and command logic for one status tick
// depends on mbs_pkg
`timescale 1ns / 1ps

module mbs_step import mbs_pkg::*; (
	input  status_t              status,
	input  seq_state_t           cur,
	input  logic [TIMEOUT_W-1:0] timeout,
	output seq_state_t           nxt,
	output result_t              res
);

	logic                 even;
	logic [TIMEOUT_W-1:0] count_inc;
	logic [CMD_W-1:0]     cmd;

	assign even      = ~cur.tick_parity;
	assign count_inc = (cur.attach_wait_count != COUNT_TOP) ?
		cur.attach_wait_count + 16'd1 : cur.attach_wait_count;

	always_comb begin
		nxt = cur;
		cmd = CMD_NONE;
		case (cur.setup_step)
			ST_IDENT: begin
				if (!status.identified) cmd = CMD_IDENT;
				else nxt.setup_step = ST_SIM;
			end
			ST_SIM: begin
				if (!status.sim_inserted) cmd = CMD_SIM;
				else nxt.setup_step = ST_PIN;
			end
			ST_PIN: begin
				if (!status.pin_ready) cmd = CMD_PIN;
				else nxt.setup_step = ST_GET_FUN;
			end
			ST_GET_FUN: begin
				cmd            = CMD_GETFUN;
				nxt.setup_step = ST_SET_FUN;
			end
			ST_SET_FUN: begin
				if (!status.full_function) begin
					cmd            = CMD_SETFULL;
					nxt.setup_step = ST_GET_FUN;
				end else begin
					nxt.setup_step = ST_GET_ATT;
					nxt.long_wait  = 1'b0;
				end
			end
			ST_SET_ATT: begin
				nxt.long_wait         = 1'b1;
				nxt.attach_wait_count = '0;
				cmd                   = CMD_SETATT;
				nxt.setup_step        = ST_GET_ATT;
			end
			ST_GET_ATT: begin
				if (status.packet_attached) begin
					nxt.setup_step = ST_NET;
				end else begin
					if (even) cmd = CMD_GETATT;
					if (cur.long_wait) begin
						nxt.attach_wait_count = count_inc;
						if (count_inc > timeout) nxt.setup_step = ST_SET_ATT;
					end else begin
						nxt.setup_step = ST_SET_ATT;
					end
				end
			end
			ST_NET: begin
				if (!status.network_registered) cmd = CMD_NETSTAT;
				else nxt.setup_step = ST_READY;
			end
			ST_READY: begin
				if (even) cmd = CMD_SIGNAL;
			end
			default: begin
				cmd = CMD_NONE;
			end
		endcase
		nxt.tick_parity = ~cur.tick_parity;
	end

	assign res.command   = cmd;
	assign res.ready_res = (nxt.setup_step == ST_READY);

endmodule

>>> rtl/core/modem_bringup_sequencer_unit.sv
// modem_bringup_sequencer_unit: top level of the modem bring-up sequencer
// depends on mbs_pkg and mbs_step
`timescale 1ns / 1ps

// one status tick in, one result out. a tick is taken every cycle while the result
// side keeps up; each result passes the input register, then the result register,
// and is offered on m_tvalid from the result register until m_tready takes it.
// the sequencer state register closes its loop through mbs_step between the
// two. the result register lets the next tick be taken while a result still
// waits for m_tready. reset starts at the identification step with the attach
// timeout at 280 ticks; cfg_we writes a new timeout, which must only happen
// while no tick is in flight.
module modem_bringup_sequencer_unit import mbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// status ticks
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [0] identified, [1] sim_inserted, [2] pin_ready, [3] full_function,
	// [4] packet_attached, [5] network_registered, [7:6] zero
	input  logic [7:0]           s_tdata,
	// command results
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [3:0] command, [4] ready_res, [7:5] zero
	output logic [7:0]           m_tdata,
	// attach timeout register
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata
);

	logic                 valid_s1;
	status_t              status_s1;
	logic                 advance;
	seq_state_t           state_q;
	seq_state_t           state_nxt;
	result_t              res_nxt;
	result_t              res_s2;
	logic                 valid_s2;
	logic [TIMEOUT_W-1:0] timeout_q;

	// stage 1 moves on when the result slot is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// attach timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			status_s1 <= status_t'(s_tdata[5:0]);
		end
	end

	mbs_step u_step (
		.status  (status_s1),
		.cur     (state_q),
		.timeout (timeout_q),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// sequencer state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.setup_step        <= ST_IDENT;
			state_q.tick_parity       <= 1'b0;
			state_q.long_wait         <= 1'b0;
			state_q.attach_wait_count <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2.ready_res, res_s2.command};

`ifndef SYNTHESIS
	// the step code stays within the nine setup steps
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.setup_step <= ST_READY)
		else $error("setup step out of range");

	// a delivered ready flag means the sequencer is and stays ready
	a_ready_match: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[4]) |-> (state_q.setup_step == ST_READY))
		else $error("ready flag without ready step");

	// every processed tick flips the parity and lands in the result slot
	a_tick_parity: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_tvalid && (state_q.tick_parity != $past(state_q.tick_parity))))
		else $error("tick not reflected in parity or result");

	// no command code beyond signal quality
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] <= CMD_SIGNAL))
		else $error("command code out of range");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for the modem bring-up sequencer with its own step predictor
// depends on mbs_pkg and modem_bringup_sequencer_unit

import mbs_pkg::*;

// tracks the sequencer state from accepted ticks and checks each command transfer
class bringup_scoreboard;
	logic [TIMEOUT_W-1:0] timeout;
	logic [STEP_W-1:0]    step;
	bit                   odd_tick;
	bit                   long_wait;
	logic [TIMEOUT_W-1:0] wait_count;
	result_t              pending_cmds[$];
	int                   errors;
	int                   checked;
	int                   resends;
	int                   signals;
	bit                   saturated;

	function new();
		timeout    = TIMEOUT_RESET;
		step       = ST_IDENT;
		odd_tick   = 1'b0;
		long_wait  = 1'b0;
		wait_count = '0;
		errors     = 0;
		checked    = 0;
		resends    = 0;
		signals    = 0;
		saturated  = 1'b0;
	endfunction

	function void set_timeout(input logic [TIMEOUT_W-1:0] value);
		timeout = value;
	endfunction

	// advance the step by one tick and queue the command it yields
	function void note_tick(input status_t st);
		result_t r;
		r.command = CMD_NONE;
		case (step)
			ST_IDENT: begin
				if (!st.identified) r.command = CMD_IDENT;
				else step = ST_SIM;
			end
			ST_SIM: begin
				if (!st.sim_inserted) r.command = CMD_SIM;
				else step = ST_PIN;
			end
			ST_PIN: begin
				if (!st.pin_ready) r.command = CMD_PIN;
				else step = ST_GET_FUN;
			end
			ST_GET_FUN: begin
				r.command = CMD_GETFUN;
				step = ST_SET_FUN;
			end
			ST_SET_FUN: begin
				if (!st.full_function) begin
					r.command = CMD_SETFULL;
					step = ST_GET_FUN;
				end else begin
					step = ST_GET_ATT;
					long_wait = 1'b0;
				end
			end
			ST_SET_ATT: begin
				long_wait = 1'b1;
				wait_count = '0;
				r.command = CMD_SETATT;
				step = ST_GET_ATT;
				resends++;
			end
			ST_GET_ATT: begin
				if (st.packet_attached) begin
					step = ST_NET;
				end else begin
					if (!odd_tick) r.command = CMD_GETATT;
					if (long_wait) begin
						if (wait_count != COUNT_TOP) wait_count++;
						else saturated = 1'b1;
						if (wait_count > timeout) step = ST_SET_ATT;
					end else begin
						step = ST_SET_ATT;
					end
				end
			end
			ST_NET: begin
				if (!st.network_registered) r.command = CMD_NETSTAT;
				else step = ST_READY;
			end
			ST_READY: begin
				if (!odd_tick) begin
					r.command = CMD_SIGNAL;
					signals++;
				end
			end
			default: ;
		endcase
		odd_tick = !odd_tick;
		r.ready_res = (step == ST_READY);
		pending_cmds.push_back(r);
	endfunction

	task report(input string msg);
		errors++;
		if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
	endtask

	task check_result(input logic [7:0] data);
		result_t want;
		if (pending_cmds.size() == 0) begin
			report($sformatf("result %h with nothing expected", data));
			return;
		end
		want = pending_cmds.pop_front();
		checked++;
		if (data[CMD_W-1:0] !== want.command)
			report($sformatf("result %0d: command %h, expected %h",
				checked, data[CMD_W-1:0], want.command));
		if (data[CMD_W] !== want.ready_res)
			report($sformatf("result %0d: ready %b, expected %b",
				checked, data[CMD_W], want.ready_res));
		if (data[7:CMD_W+1] !== '0)
			report($sformatf("result %0d: padding bits %b not zero",
				checked, data[7:CMD_W+1]));
	endtask
endclass

module tb_top;

	// long receiver hold-off used once to back the block up into its input
	localparam int HOLD_CYCLES = 60;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	// [0] identified, [1] sim_inserted, [2] pin_ready, [3] full_function,
	// [4] packet_attached, [5] network_registered, [7:6] zero
	logic [7:0]           s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// [3:0] command, [4] ready_res, [7:5] zero
	logic [7:0]           m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [TIMEOUT_W-1:0] cfg_wdata = '0;

	bringup_scoreboard sb = new();

	// receiver modes, set by the main sequence
	bit rx_fast        = 1'b0;
	bit pressure_armed = 1'b0;
	bit pressure_done  = 1'b0;

	// opening walk through the early setup steps
	status_t walk_ticks [15];

	modem_bringup_sequencer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("run timed out with %0d results outstanding", sb.pending_cmds.size());
		$display("Verification failed");
		$finish;
	end

	// result side: every command transfer goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) sb.check_result(m_tdata);
	end

	// receiver stalls from a 16-bit pattern, one bit per slot, redrawn each time it runs out;
	// one long hold-off while pressure is armed, full speed during the steady run
	initial begin : rx_side
		logic [15:0] pattern;
		int          slot;
		pattern = '1;
		slot    = 0;
		forever begin
			@(posedge clk);
			if (pressure_armed && !pressure_done && m_tvalid === 1'b1) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				pressure_done = 1'b1;
			end else if (rx_fast) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= pattern[slot];
				slot++;
				if (slot == 16) begin
					slot = 0;
					case ($urandom_range(0, 3))
						0:       pattern = '1;
						1:       pattern = 16'($urandom);
						2:       pattern = 16'($urandom | $urandom);
						default: pattern = 16'($urandom & $urandom);
					endcase
				end
			end
		end
	end

	// offer one tick and hold it until the transfer; called right after a rising edge
	task automatic offer(input status_t st);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, st};
		do @(posedge clk); while (!(s_tvalid && s_tready === 1'b1));
		sb.note_tick(st);
	endtask

	// random flags, with the flag that decides the current step steered
	function automatic status_t pick_status(input bit hold_attach);
		status_t st;
		st = status_t'($urandom_range(0, 63));
		if (sb.step == ST_GET_ATT)
			st.packet_attached = hold_attach ? 1'b0 : 1'($urandom_range(0, 7) == 0);
		if (sb.step == ST_NET)
			st.network_registered = 1'($urandom_range(0, 3) == 0);
		return st;
	endfunction

	// bursts of ticks with random gaps, or back to back when steady
	task automatic send_ticks(input int count, input bit hold_attach, input bit steady);
		int burst;
		burst = $urandom_range(1, 24);
		for (int i = 0; i < count; i++) begin
			if (!steady && burst == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
			end
			offer(pick_status(hold_attach));
			if (burst > 0) burst--;
		end
		s_tvalid <= 1'b0;
	endtask

	// all results in, plus the two-stage pipeline depth and some margin
	task automatic wait_idle();
		while (sb.pending_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_timeout(value);
	endtask

	initial begin : main_seq
		// flags listed from network_registered down to identified
		walk_ticks = '{
			6'b000000,  // not identified: ident query
			6'b111110,  // every other flag high, still not identified
			6'b000001,  // identified: on to the sim check
			6'b111101,  // no sim: sim query
			6'b000010,  // sim in: on to the pin check
			6'b111011,  // pin not ready: pin query
			6'b000100,  // pin ready
			6'b000000,  // function query, whatever the flags
			6'b110111,  // not full function: set full, back to the query
			6'b111111,  // function query again
			6'b001000,  // full function: into attach wait with no request yet
			6'b000000,  // no request made: straight to the attach request, odd tick
			6'b101111,  // attach request
			6'b101111,  // odd tick in attach wait: nothing issued
			6'b000000   // even tick: attach query
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (walk_ticks[i]) offer(walk_ticks[i]);

		// attach wait at the reset timeout, long enough for a re-send
		send_ticks(500, 1'b1, 1'b0);

		// smallest timeouts: re-send after one or two waiting ticks
		write_timeout('0);
		send_ticks(120, 1'b1, 1'b0);
		write_timeout(16'd1);
		send_ticks(120, 1'b1, 1'b0);
		write_timeout(16'($urandom_range(2, 40)));
		send_ticks(300, 1'b1, 1'b0);

		// largest timeout: the wait counter only climbs, no re-send
		write_timeout(COUNT_TOP);
		rx_fast = 1'b1;
		send_ticks(100, 1'b1, 1'b1);
		wait_idle();
		rx_fast = 1'b0;

		// lower timeout under the running count, and the receiver backs the block up
		pressure_armed = 1'b1;
		write_timeout(16'($urandom_range(2, 100)));
		send_ticks(200, 1'b1, 1'b0);

		// let attach and registration through, then stay in the ready step
		write_timeout(TIMEOUT_RESET);
		send_ticks(300, 1'b0, 1'b0);

		wait_idle();
		repeat (8) @(posedge clk);

		$display("checked %0d command transfers: %0d attach requests, %0d signal queries, %s",
			sb.checked, sb.resends, sb.signals,
			sb.saturated ? "wait counter held at its ceiling" : "wait counter never at its ceiling");
		$display("attach timeouts of 0, 1, small random values, 280 and 65535; final step %0d",
			sb.step);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/mbs_pkg.sv
rtl/core/mbs_step.sv
rtl/core/modem_bringup_sequencer_unit.sv
tb/sv/tb_top.sv
